FILE: rtl/rtdc_pkg.sv
// shared types and constants of the real-to-iq down-converter
package rtdc_pkg;

  localparam int MAX_DECIM_LOG2 = 8;
  localparam int PHASE_BITS     = 32;

  localparam int ANG_W        = 32;
  localparam int SAMPLE_W     = 16;
  localparam int SEFF_W       = SAMPLE_W + 1;
  localparam int XY_W         = 32;
  localparam int Z_W          = 33;
  localparam int CORDIC_STEPS = 16;
  localparam int PROD_W       = SEFF_W + XY_W;
  localparam int FRAC_W       = 30;
  localparam int V_W          = SAMPLE_W + 1;
  localparam int SUM_W        = V_W + MAX_DECIM_LOG2;
  localparam int CNT_W        = MAX_DECIM_LOG2;
  localparam int K_W          = $clog2(MAX_DECIM_LOG2 + 1);
  localparam int DECIM_W      = 4;
  localparam int CFG_W        = 32;
  localparam int CFG_ADDR_W   = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PHASE_INC  = 1'b0,
    REG_DECIM_LOG2 = 1'b1
  } cfg_reg_t;

  typedef logic signed [Z_W-1:0]  angle_t;
  typedef logic signed [XY_W-1:0] xy_t;

  localparam logic [CFG_W-1:0]   PHASE_INC_RESET = 32'hF800_0000;
  localparam logic [DECIM_W-1:0] DECIM_RESET     = 4'd4;

  localparam xy_t    CORDIC_START = 32'sd652032874;
  localparam angle_t QUARTER_TURN = 33'sd1073741824;
  localparam angle_t HALF_TURN    = 33'sd2147483648;

  localparam angle_t ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
  };

  // product rounding: half an lsb of the result once the q30 fraction bits are dropped
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

  localparam int V_LIM   = 2 ** (SAMPLE_W - 1);
  localparam int OUT_MAX = 2 ** (SAMPLE_W - 1) - 1;

endpackage

FILE: rtl/real_to_iq_downconverter_unit.sv
// real-to-iq down-converter: nco mixer with cordic and averaging decimator
//
// Input channel (in_valid / in_stall / in_sample): one signed 16-bit real
// sample per beat, one beat per clock when not stalled. Each sample is mixed
// with the nco phase (i = -s*sin, q = s*cos) and groups of 2^decim_log2 mixed
// samples (decim_log2 capped at 8) are averaged, rounded and saturated into
// one out_i_out / out_q_out beat on the result channel (out_valid / out_stall).
// Each sample of a group passes 17 cordic stages, one multiply stage and one
// rounding stage, then is accumulated into the output register.
// Throughput: one sample per clock when not stalled, set by the fully
// pipelined cordic, so at most one result beat leaves per group of samples.
// When out_stall holds a result, samples that do not close a group still
// drain into the accumulator; the pipe fills and in_stall rises only once a
// group-closing sample waits at the accumulator.
// Reset (rst_n low, synchronous) empties the pipe, zeroes the nco phase and
// the partial group and loads the register defaults. cfg writes belong only
// in an empty pipe; a decim_log2 write drops the partial group.
module real_to_iq_downconverter_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rtdc_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rtdc_pkg::SAMPLE_W-1:0]   out_i_out,
  output logic signed [rtdc_pkg::SAMPLE_W-1:0]   out_q_out,
  input  logic                                   cfg_we,
  input  logic [rtdc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [rtdc_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int CS = rtdc_pkg::CORDIC_STEPS;

  function automatic logic [rtdc_pkg::K_W-1:0] eff_k(input logic [rtdc_pkg::DECIM_W-1:0] d);
    eff_k = (int'(d) > rtdc_pkg::MAX_DECIM_LOG2) ? rtdc_pkg::K_W'(rtdc_pkg::MAX_DECIM_LOG2)
                                                 : d[rtdc_pkg::K_W-1:0];
  endfunction

  // rounding bias preloaded into the sums: half of 2^k, zero for k = 0
  function automatic logic signed [rtdc_pkg::SUM_W-1:0] bias_of(
    input logic [rtdc_pkg::K_W-1:0] k
  );
    logic [rtdc_pkg::SUM_W-1:0] b;
    b = (rtdc_pkg::SUM_W'(1) << k) >> 1;
    bias_of = signed'(b);
  endfunction

  function automatic logic signed [rtdc_pkg::V_W-1:0] clamp_v(
    input logic signed [rtdc_pkg::PROD_W-1:0] t
  );
    if (t > rtdc_pkg::PROD_W'(rtdc_pkg::V_LIM))
      clamp_v = rtdc_pkg::V_W'(rtdc_pkg::V_LIM);
    else if (t < -rtdc_pkg::PROD_W'(rtdc_pkg::V_LIM))
      clamp_v = -rtdc_pkg::V_W'(rtdc_pkg::V_LIM);
    else
      clamp_v = t[rtdc_pkg::V_W-1:0];
  endfunction

  function automatic logic signed [rtdc_pkg::SAMPLE_W-1:0] sat_out(
    input logic signed [rtdc_pkg::SUM_W-1:0] t
  );
    if (t > rtdc_pkg::SUM_W'(rtdc_pkg::OUT_MAX))
      sat_out = rtdc_pkg::SAMPLE_W'(rtdc_pkg::OUT_MAX);
    else if (t < -rtdc_pkg::SUM_W'(rtdc_pkg::V_LIM))
      sat_out = -rtdc_pkg::SAMPLE_W'(rtdc_pkg::V_LIM);
    else
      sat_out = t[rtdc_pkg::SAMPLE_W-1:0];
  endfunction

  // configuration and nco
  logic [rtdc_pkg::CFG_W-1:0]       phase_inc_r;
  logic [rtdc_pkg::DECIM_W-1:0]     decim_log2_r;
  logic [rtdc_pkg::PHASE_BITS-1:0]  phase_acc_r;
  logic [rtdc_pkg::PHASE_BITS-1:0]  inc_top;
  logic [rtdc_pkg::ANG_W-1:0]       ang;
  rtdc_pkg::angle_t                 z_in;
  logic                             flip_in;
  logic signed [rtdc_pkg::SEFF_W-1:0] s_in;
  logic [rtdc_pkg::K_W-1:0]         k_eff;
  logic [rtdc_pkg::K_W-1:0]         k_new;

  // cordic pipe
  logic                             c_v_r [CS+1];
  logic                             c_rdy [CS+1];
  rtdc_pkg::xy_t                    x_r   [CS+1];
  rtdc_pkg::xy_t                    y_r   [CS+1];
  rtdc_pkg::angle_t                 z_r   [CS+1];
  logic signed [rtdc_pkg::SEFF_W-1:0] s_r [CS+1];
  rtdc_pkg::xy_t                    x_nxt [CS];
  rtdc_pkg::xy_t                    y_nxt [CS];
  rtdc_pkg::angle_t                 z_nxt [CS];

  // multiply, round and accumulate
  logic                                 p_v_r;
  logic                                 p_rdy;
  logic signed [rtdc_pkg::PROD_W-1:0]   p_i_r, p_q_r;
  logic signed [rtdc_pkg::PROD_W-1:0]   p_i_nxt, p_q_nxt;
  logic                                 v_v_r;
  logic                                 v_rdy;
  logic signed [rtdc_pkg::V_W-1:0]      v_i_r, v_q_r;
  logic signed [rtdc_pkg::V_W-1:0]      v_i_nxt, v_q_nxt;
  logic signed [rtdc_pkg::SUM_W-1:0]    sum_i_r, sum_q_r;
  logic signed [rtdc_pkg::SUM_W-1:0]    sum_i_nxt, sum_q_nxt;
  logic [rtdc_pkg::CNT_W-1:0]           grp_cnt_r;
  logic [rtdc_pkg::CNT_W-1:0]           grp_lim;
  logic                                 grp_last;
  logic                                 acc_take;
  logic                                 out_free;
  logic                                 out_valid_r;
  logic signed [rtdc_pkg::SAMPLE_W-1:0] out_i_r, out_q_r;
  logic signed [rtdc_pkg::SAMPLE_W-1:0] out_i_nxt, out_q_nxt;

  assign k_eff   = eff_k(decim_log2_r);
  assign k_new   = eff_k(cfg_wdata[rtdc_pkg::DECIM_W-1:0]);
  assign inc_top = phase_inc_r[rtdc_pkg::CFG_W-1 -: rtdc_pkg::PHASE_BITS];
  assign ang     = rtdc_pkg::ANG_W'(phase_acc_r) << (rtdc_pkg::ANG_W - rtdc_pkg::PHASE_BITS);

  // fold the angle into +-1/4 turn; the flip is carried as a negated sample
  always_comb begin
    z_in    = rtdc_pkg::Z_W'(signed'(ang));
    flip_in = 1'b0;
    if (z_in > rtdc_pkg::QUARTER_TURN || z_in < -rtdc_pkg::QUARTER_TURN) begin
      flip_in = 1'b1;
      if (z_in > 0)
        z_in = z_in - rtdc_pkg::HALF_TURN;
      else
        z_in = z_in + rtdc_pkg::HALF_TURN;
    end
    s_in = flip_in ? -rtdc_pkg::SEFF_W'(in_sample) : rtdc_pkg::SEFF_W'(in_sample);
  end

  // one micro-rotation per stage
  always_comb begin
    for (int j = 0; j < CS; j++) begin
      if (!z_r[j][rtdc_pkg::Z_W-1]) begin
        x_nxt[j] = x_r[j] - (y_r[j] >>> j);
        y_nxt[j] = y_r[j] + (x_r[j] >>> j);
        z_nxt[j] = z_r[j] - rtdc_pkg::ATAN_TAB[j];
      end else begin
        x_nxt[j] = x_r[j] + (y_r[j] >>> j);
        y_nxt[j] = y_r[j] - (x_r[j] >>> j);
        z_nxt[j] = z_r[j] + rtdc_pkg::ATAN_TAB[j];
      end
    end
  end

  assign p_i_nxt = rtdc_pkg::PROD_W'(s_r[CS]) * rtdc_pkg::PROD_W'(y_r[CS]);
  assign p_q_nxt = rtdc_pkg::PROD_W'(s_r[CS]) * rtdc_pkg::PROD_W'(x_r[CS]);

  // ~p + 1 + half gives -p + half
  assign v_i_nxt = clamp_v((~p_i_r + rtdc_pkg::RND_HALF + rtdc_pkg::PROD_W'(1))
                           >>> rtdc_pkg::FRAC_W);
  assign v_q_nxt = clamp_v((p_q_r + rtdc_pkg::RND_HALF) >>> rtdc_pkg::FRAC_W);

  assign sum_i_nxt = sum_i_r + rtdc_pkg::SUM_W'(v_i_r);
  assign sum_q_nxt = sum_q_r + rtdc_pkg::SUM_W'(v_q_r);
  assign out_i_nxt = sat_out(sum_i_nxt >>> k_eff);
  assign out_q_nxt = sat_out(sum_q_nxt >>> k_eff);

  assign grp_lim  = rtdc_pkg::CNT_W'((rtdc_pkg::SUM_W'(1) << k_eff) - rtdc_pkg::SUM_W'(1));
  assign grp_last = (grp_cnt_r == grp_lim);

  // ready chain: only a group-closing beat waits on the output register
  assign out_free = !out_valid_r || !out_stall;
  assign acc_take = v_v_r && (!grp_last || out_free);
  assign v_rdy    = !v_v_r || acc_take;
  assign p_rdy    = !p_v_r || v_rdy;

  always_comb begin
    c_rdy[CS] = !c_v_r[CS] || p_rdy;
    for (int j = CS - 1; j >= 0; j--) begin
      c_rdy[j] = !c_v_r[j] || c_rdy[j+1];
    end
  end

  assign in_stall  = !c_rdy[0];
  assign out_valid = out_valid_r;
  assign out_i_out = out_i_r;
  assign out_q_out = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= CS; j++) begin
        c_v_r[j] <= 1'b0;
      end
      p_v_r        <= 1'b0;
      v_v_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_inc_r  <= rtdc_pkg::PHASE_INC_RESET;
      decim_log2_r <= rtdc_pkg::DECIM_RESET;
      phase_acc_r  <= '0;
      grp_cnt_r    <= '0;
      sum_i_r      <= bias_of(eff_k(rtdc_pkg::DECIM_RESET));
      sum_q_r      <= bias_of(eff_k(rtdc_pkg::DECIM_RESET));
    end else begin
      if (c_rdy[0]) begin
        c_v_r[0] <= in_valid;
      end
      for (int j = 1; j <= CS; j++) begin
        if (c_rdy[j]) begin
          c_v_r[j] <= c_v_r[j-1];
        end
      end
      if (p_rdy) begin
        p_v_r <= c_v_r[CS];
      end
      if (v_rdy) begin
        v_v_r <= p_v_r;
      end
      if (in_valid && !in_stall) begin
        phase_acc_r <= phase_acc_r + inc_top;
      end
      if (acc_take) begin
        if (grp_last) begin
          grp_cnt_r <= '0;
          sum_i_r   <= bias_of(k_eff);
          sum_q_r   <= bias_of(k_eff);
        end else begin
          grp_cnt_r <= grp_cnt_r + rtdc_pkg::CNT_W'(1);
          sum_i_r   <= sum_i_nxt;
          sum_q_r   <= sum_q_nxt;
        end
      end
      if (acc_take && grp_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (rtdc_pkg::cfg_reg_t'(cfg_addr))
          rtdc_pkg::REG_PHASE_INC: begin
            phase_inc_r <= cfg_wdata;
          end
          rtdc_pkg::REG_DECIM_LOG2: begin
            decim_log2_r <= cfg_wdata[rtdc_pkg::DECIM_W-1:0];
            grp_cnt_r    <= '0;
            sum_i_r      <= bias_of(k_new);
            sum_q_r      <= bias_of(k_new);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (c_rdy[0]) begin
      x_r[0] <= rtdc_pkg::CORDIC_START;
      y_r[0] <= '0;
      z_r[0] <= z_in;
      s_r[0] <= s_in;
    end
    for (int j = 1; j <= CS; j++) begin
      if (c_rdy[j]) begin
        x_r[j] <= x_nxt[j-1];
        y_r[j] <= y_nxt[j-1];
        z_r[j] <= z_nxt[j-1];
        s_r[j] <= s_r[j-1];
      end
    end
    if (p_rdy) begin
      p_i_r <= p_i_nxt;
      p_q_r <= p_q_nxt;
    end
    if (v_rdy) begin
      v_i_r <= v_i_nxt;
      v_q_r <= v_q_nxt;
    end
    if (acc_take && grp_last) begin
      out_i_r <= out_i_nxt;
      out_q_r <= out_q_nxt;
    end
  end

endmodule

FILE: rtl/rtdc_chk.sv
// port-level checks of the real-to-iq down-converter, bound to the top level
module rtdc_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [rtdc_pkg::SAMPLE_W-1:0] out_i_out,
  input logic signed [rtdc_pkg::SAMPLE_W-1:0] out_q_out
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_i_out) && $stable(out_q_out))
    else $error("result beat changed while stalled");

  // backpressure only ever comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind real_to_iq_downconverter_unit rtdc_chk u_rtdc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_i_out (out_i_out),
  .out_q_out (out_q_out)
);
